// ----- sv/pde_pkg.sv -----
// ----------------------------------------------------------------------------
// pde_pkg
// Shared types, constants and square arithmetic for the Playfair digraph
// encryptor: beat structs, operation codes, controller states and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pde_pkg;

	localparam int LETTER_W     = 5;
	localparam int COORD_W      = 3;
	localparam int SQUARE_SIDE  = 5;
	localparam int SQUARE_CELLS = 25;
	localparam int LETTER_COUNT = 26;

	typedef logic [LETTER_W-1:0] letter_t;
	typedef logic [COORD_W-1:0]  coord_t;

	localparam letter_t NUM_CELLS   = letter_t'(SQUARE_CELLS);
	localparam letter_t NUM_LETTERS = letter_t'(LETTER_COUNT);
	localparam letter_t LETTER_Q    = 5'd16;
	localparam letter_t LETTER_X    = 5'd23;
	localparam coord_t  SIDE_LAST   = coord_t'(SQUARE_SIDE - 1);

	// Operation codes of an input beat.
	typedef enum logic [2:0] {
		OP_NEW_KEY     = 3'd0,
		OP_KEY_LETTER  = 3'd1,
		OP_FINISH_KEY  = 3'd2,
		OP_TEXT_LETTER = 3'd3,
		OP_END_TEXT    = 3'd4
	} op_t;

	typedef struct packed {
		logic [2:0] operation;
		letter_t    letter;
	} item_t;

	typedef struct packed {
		letter_t cipher_letter;
		logic    has_letter;
		logic    end_of_message;
	} result_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FILL,
		ST_READ_B,
		ST_CALC,
		ST_READ_OB,
		ST_EMIT_A,
		ST_EMIT_B,
		ST_EMIT_END
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic read_a;
		logic read_b;
		logic calc;
		logic read_ob;
		logic fill_step;
		logic load_a;
		logic load_b;
		logic load_e;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic pair_start;
		logic end_empty;
		logic finish;
		logic fill_last;
		logic out_free;
	} dp_status_t;

	// A letter that can stand in the square.
	function automatic logic letter_ok(letter_t l);
		return (l < NUM_LETTERS) && (l != LETTER_Q);
	endfunction

	// Row of a cell index, by comparison against the row starts.
	function automatic coord_t cell_row(letter_t idx);
		coord_t r;
		r = '0;
		for (int k = 1; k < SQUARE_SIDE; k++) begin
			if (idx >= letter_t'(k * SQUARE_SIDE))
				r = coord_t'(k);
		end
		return r;
	endfunction

	function automatic letter_t cell_index(coord_t r, coord_t c);
		return letter_t'({2'b00, r} * letter_t'(SQUARE_SIDE)) + letter_t'({2'b00, c});
	endfunction

	function automatic coord_t cell_col(letter_t idx);
		letter_t base;
		base = cell_index(cell_row(idx), '0);
		return coord_t'(idx - base);
	endfunction

	// Step one row or column forward with wrap.
	function automatic coord_t wrap_inc(coord_t v);
		return (v == SIDE_LAST) ? '0 : coord_t'(v + coord_t'(1));
	endfunction

endpackage

// ----- sv/pde_ram.sv -----
// ----------------------------------------------------------------------------
// pde_ram
// Generic single-write, single-read RAM with a registered read port. The
// read data holds its value while no read is enabled.
// ----------------------------------------------------------------------------
module pde_ram import pde_pkg::*; #(
	parameter int WIDTH = LETTER_W,
	parameter int DEPTH = LETTER_COUNT
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem_q[raddr];
	end

endmodule

// ----- sv/pde_ctrl.sv -----
// ----------------------------------------------------------------------------
// pde_ctrl
// Controller of the Playfair encryptor. Takes one input beat at a time in
// idle, walks the key fill, sequences the table reads of a pair and paces
// the result beats against the output register.
// ----------------------------------------------------------------------------
module pde_ctrl import pde_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  dp_status_t st,
	output ctrl_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// Next state and commands.
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				cmd.accept = item_valid;
				if (item_valid) begin
					if (st.finish) begin
						state_d = ST_FILL;
					end else if (st.pair_start) begin
						cmd.read_a = 1'b1;
						state_d    = ST_READ_B;
					end else if (st.end_empty) begin
						state_d = ST_EMIT_END;
					end
				end
			end
			ST_FILL: begin
				cmd.fill_step = 1'b1;
				if (st.fill_last)
					state_d = ST_IDLE;
			end
			ST_READ_B: begin
				cmd.read_b = 1'b1;
				state_d    = ST_CALC;
			end
			ST_CALC: begin
				cmd.calc = 1'b1;
				state_d  = ST_READ_OB;
			end
			ST_READ_OB: begin
				cmd.read_ob = 1'b1;
				state_d     = ST_EMIT_A;
			end
			ST_EMIT_A: begin
				if (st.out_free) begin
					cmd.load_a = 1'b1;
					state_d    = ST_EMIT_B;
				end
			end
			ST_EMIT_B: begin
				if (st.out_free) begin
					cmd.load_b = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			ST_EMIT_END: begin
				if (st.out_free) begin
					cmd.load_e = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// A result is never loaded over one that is still waiting.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load_a || cmd.load_b || cmd.load_e) |-> st.out_free)
		else $error("result loaded while output register busy");

	// At most one datapath step is commanded per cycle.
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.read_a, cmd.read_b, cmd.calc, cmd.read_ob, cmd.fill_step,
			cmd.load_a, cmd.load_b, cmd.load_e}))
		else $error("more than one datapath step commanded");

endmodule

// ----- sv/pde_dp.sv -----
// ----------------------------------------------------------------------------
// pde_dp
// Datapath of the Playfair encryptor: the key square and letter-to-cell
// tables, the used marks and fill position, the held text letter, the pair
// geometry and the output register.
// ----------------------------------------------------------------------------
module pde_dp import pde_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  item_t      item,
	input  ctrl_cmd_t  cmd,
	output dp_status_t st,
	output result_t    result,
	output logic       result_valid,
	input  logic       result_stall
);

	logic [LETTER_COUNT-1:0] used_q;
	letter_t fill_q;
	letter_t walk_q;
	letter_t held_letter_q;
	logic    held_valid_q;
	letter_t b_q;
	logic    last_q;
	letter_t pa_q;
	letter_t oa_q;
	letter_t ob_idx_q;
	result_t result_q;
	logic    result_valid_q;

	logic    in_ok;
	logic    is_new_key;
	logic    is_key_letter;
	logic    is_text;
	logic    is_end;
	logic    pair_text;
	logic    pair_end;
	letter_t place_l;
	logic    place_req;
	logic    place_en;
	letter_t col_rdata;
	letter_t sq_rdata;
	letter_t col_raddr;
	letter_t sq_raddr;
	letter_t oa_idx;
	letter_t ob_idx;
	coord_t  ra, ca, rb, cb;

	// Decode of the input beat.
	always_comb begin
		in_ok         = letter_ok(item.letter);
		is_new_key    = (item.operation == OP_NEW_KEY);
		is_key_letter = (item.operation == OP_KEY_LETTER);
		is_text       = (item.operation == OP_TEXT_LETTER);
		is_end        = (item.operation == OP_END_TEXT);
		pair_text     = is_text && in_ok && held_valid_q;
		pair_end      = is_end && held_valid_q;
		st.pair_start = pair_text || pair_end;
		st.end_empty  = is_end && !held_valid_q;
		st.finish     = (item.operation == OP_FINISH_KEY);
		st.fill_last  = (walk_q == NUM_LETTERS - letter_t'(1));
		st.out_free   = !result_valid_q || !result_stall;
	end

	// Key placement: a key letter beat or one step of the finishing walk.
	always_comb begin
		place_l   = cmd.fill_step ? walk_q : item.letter;
		place_req = (cmd.accept && is_key_letter && in_ok) ||
			(cmd.fill_step && (walk_q != LETTER_Q));
		place_en  = place_req && (fill_q < NUM_CELLS) && !used_q[place_l];
	end

	// Used marks, fill position and the finishing walk counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			fill_q <= '0;
			walk_q <= '0;
		end else begin
			if (cmd.accept && is_new_key) begin
				used_q <= '0;
				fill_q <= '0;
			end else if (place_en) begin
				used_q[place_l] <= 1'b1;
				fill_q          <= fill_q + letter_t'(1);
			end
			if (cmd.accept && st.finish)
				walk_q <= '0;
			else if (cmd.fill_step)
				walk_q <= walk_q + letter_t'(1);
		end
	end

	// Held text letter; a doubled letter stays held for the next pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_letter_q <= '0;
			held_valid_q  <= 1'b0;
		end else if (cmd.accept) begin
			if (is_new_key || is_end) begin
				held_valid_q <= 1'b0;
			end else if (is_text && in_ok) begin
				if (!held_valid_q) begin
					held_letter_q <= item.letter;
					held_valid_q  <= 1'b1;
				end else if (held_letter_q != item.letter) begin
					held_valid_q <= 1'b0;
				end
			end
		end
	end

	// Second letter of the pair and whether it ends the message.
	always_ff @(posedge clk) begin
		if (cmd.read_a) begin
			b_q    <= (pair_end || held_letter_q == item.letter) ? LETTER_X : item.letter;
			last_q <= pair_end;
		end
	end

	// Letter-to-cell table.
	assign col_raddr = cmd.read_b ? b_q : held_letter_q;

	pde_ram #(
		.WIDTH(LETTER_W),
		.DEPTH(LETTER_COUNT)
	) u_cell_of_letter (
		.clk  (clk),
		.we   (place_en),
		.waddr(place_l),
		.wdata(fill_q),
		.re   (cmd.read_a || cmd.read_b),
		.raddr(col_raddr),
		.rdata(col_rdata)
	);

	// Pair geometry: same row, same column, or rectangle corners.
	always_comb begin
		ra = cell_row(pa_q);
		ca = cell_col(pa_q);
		rb = cell_row(col_rdata);
		cb = cell_col(col_rdata);
		if ((held_letter_q == b_q) || (ra == rb)) begin
			oa_idx = cell_index(ra, wrap_inc(ca));
			ob_idx = cell_index(rb, wrap_inc(cb));
		end else if (ca == cb) begin
			oa_idx = cell_index(wrap_inc(ra), ca);
			ob_idx = cell_index(wrap_inc(rb), cb);
		end else begin
			oa_idx = cell_index(ra, cb);
			ob_idx = cell_index(rb, ca);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.read_b)
			pa_q <= col_rdata;
		if (cmd.calc)
			ob_idx_q <= ob_idx;
		if (cmd.read_ob)
			oa_q <= sq_rdata;
	end

	// Key square table.
	assign sq_raddr = cmd.calc ? oa_idx : ob_idx_q;

	pde_ram #(
		.WIDTH(LETTER_W),
		.DEPTH(SQUARE_CELLS)
	) u_square (
		.clk  (clk),
		.we   (place_en),
		.waddr(fill_q),
		.wdata(place_l),
		.re   (cmd.calc || cmd.read_ob),
		.raddr(sq_raddr),
		.rdata(sq_rdata)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_q <= 1'b0;
		else if (cmd.load_a || cmd.load_b || cmd.load_e)
			result_valid_q <= 1'b1;
		else if (!result_stall)
			result_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_a)
			result_q <= '{cipher_letter: oa_q, has_letter: 1'b1, end_of_message: 1'b0};
		else if (cmd.load_b)
			result_q <= '{cipher_letter: sq_rdata, has_letter: 1'b1, end_of_message: last_q};
		else if (cmd.load_e)
			result_q <= '{cipher_letter: '0, has_letter: 1'b0, end_of_message: 1'b1};
	end

	assign result       = result_q;
	assign result_valid = result_valid_q;

	// The fill position never runs past the last cell.
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= NUM_CELLS)
		else $error("fill position beyond the square");

	// A held letter is always one that lives in the square.
	a_held_ok: assert property (@(posedge clk) disable iff (!arst_n)
		held_valid_q |-> letter_ok(held_letter_q))
		else $error("held letter outside the square alphabet");

	// An empty end of text produces a letterless end-of-message beat.
	a_end_beat: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_e |=> (result_valid_q && !result_q.has_letter && result_q.end_of_message))
		else $error("empty end of text beat malformed");

endmodule

// ----- sv/playfair_digraph_encryptor.sv -----
// ----------------------------------------------------------------------------
// playfair_digraph_encryptor
// Playfair encryption over a 5x5 key square without Q, built from the input
// stream and applied to text letters taken in pairs.
// ----------------------------------------------------------------------------
// The block takes one input beat at a time. New key and key letter beats
// end in idle. Finish key then walks all 26 letters one per cycle, since
// each placement writes both tables. A text letter that only becomes held
// ends in idle; one that completes a pair, and an end of text with a held
// letter, read the letter-to-cell table and then the square twice each in
// turn, as each has a single read port, and emit two beats. An end of text
// with nothing held emits one beat. Emits wait while the output stalls.
// Result beats leave through an output register, so the last result of an
// item may wait there while the next item is taken.
module playfair_digraph_encryptor import pde_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  item_t   item,
	input  logic    item_valid,
	output logic    item_stall,
	output result_t result,
	output logic    result_valid,
	input  logic    result_stall
);

	ctrl_cmd_t  cmd;
	dp_status_t st;

	// Sequencer.
	pde_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.st        (st),
		.cmd       (cmd)
	);

	// Tables, key state and output register.
	pde_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.cmd         (cmd),
		.st          (st),
		.result      (result),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

endmodule

// ----- test/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Playfair digraph encryptor. Input beats build
// key squares and feed text through the block under random idle and stall
// patterns. A behavioral model of the cipher predicts every result beat, and
// each accepted result is checked field by field against the oldest one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
	import pde_pkg::*;

	localparam int      IDLE_LIMIT   = 1000;
	localparam int      TAIL_CYCLES  = 32;
	localparam letter_t BEYOND_Z     = 5'd26;
	localparam letter_t TOP_CODE     = 5'd31;
	localparam logic [2:0] OP_UNUSED = 3'd7;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	item_t   item         = '0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	result_t result;
	logic    result_valid;
	logic    result_stall = 1'b0;

	// Cipher state as the block should hold it.
	letter_t                 key_square [SQUARE_CELLS];
	letter_t                 cell_of    [LETTER_COUNT];
	logic [LETTER_COUNT-1:0] taken_letters;
	int                      fill_next;
	letter_t                 held_letter;
	logic                    holding;
	result_t                 expected_cipher [$];

	int send_idle_pct  = 0;
	int recv_stall_pct = 0;
	int items_sent     = 0;
	int mismatches     = 0;
	int idle_cycles    = 0;
	result_t want;

	playfair_digraph_encryptor uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.item        (item),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.result      (result),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

	always #2 clk = ~clk;

	// Letter code of an upper-case character.
	function automatic letter_t code_of(input byte ch);
		return letter_t'(ch - 8'd65);
	endfunction

	function automatic logic square_letter(input letter_t l);
		return (l <= code_of("Z")) && (l != LETTER_Q);
	endfunction

	function automatic letter_t any_square_letter();
		letter_t l;
		l = letter_t'($urandom_range(25));
		return (l == LETTER_Q) ? LETTER_X : l;
	endfunction

	function automatic void clear_cipher_state();
		int i;
		for (i = 0; i < SQUARE_CELLS; i++)
			key_square[i] = '0;
		for (i = 0; i < LETTER_COUNT; i++)
			cell_of[i] = '0;
		taken_letters = '0;
		fill_next     = 0;
		held_letter   = '0;
		holding       = 1'b0;
	endfunction

	// Put a letter in the next free cell unless the square is full or it is there.
	function automatic void place_in_square(input letter_t l);
		if (fill_next < SQUARE_CELLS && !taken_letters[l]) begin
			key_square[fill_next] = l;
			cell_of[l]            = letter_t'(fill_next);
			taken_letters[l]      = 1'b1;
			fill_next++;
		end
	endfunction

	function automatic letter_t square_at(input int r, input int c);
		return key_square[(r % SQUARE_SIDE) * SQUARE_SIDE + (c % SQUARE_SIDE)];
	endfunction

	// Encrypt one pair and queue its two cipher letters.
	function automatic void encode_digraph(input letter_t a, input letter_t b,
			input logic last);
		int pa, pb, ra, ca, rb, cb;
		letter_t oa, ob;
		pa = int'(cell_of[a]) % SQUARE_CELLS;
		pb = int'(cell_of[b]) % SQUARE_CELLS;
		ra = pa / SQUARE_SIDE;
		ca = pa % SQUARE_SIDE;
		rb = pb / SQUARE_SIDE;
		cb = pb % SQUARE_SIDE;
		if (a == b || ra == rb) begin
			oa = square_at(ra, ca + 1);
			ob = square_at(rb, cb + 1);
		end else if (ca == cb) begin
			oa = square_at(ra + 1, ca);
			ob = square_at(rb + 1, cb);
		end else begin
			oa = square_at(ra, cb);
			ob = square_at(rb, ca);
		end
		expected_cipher.push_back('{cipher_letter: oa, has_letter: 1'b1,
			end_of_message: 1'b0});
		expected_cipher.push_back('{cipher_letter: ob, has_letter: 1'b1,
			end_of_message: last});
	endfunction

	// Advance the cipher state by one accepted beat.
	function automatic void predict_cipher(input logic [2:0] op, input letter_t l);
		int i;
		case (op)
			OP_NEW_KEY: begin
				taken_letters = '0;
				fill_next     = 0;
				holding       = 1'b0;
			end
			OP_KEY_LETTER: begin
				if (square_letter(l))
					place_in_square(l);
			end
			OP_FINISH_KEY: begin
				for (i = 0; i < LETTER_COUNT; i++)
					if (letter_t'(i) != LETTER_Q)
						place_in_square(letter_t'(i));
			end
			OP_TEXT_LETTER: begin
				if (square_letter(l)) begin
					if (!holding) begin
						held_letter = l;
						holding     = 1'b1;
					end else if (held_letter == l) begin
						// The doubled letter stays held for the next pair.
						encode_digraph(held_letter, LETTER_X, 1'b0);
					end else begin
						encode_digraph(held_letter, l, 1'b0);
						holding = 1'b0;
					end
				end
			end
			OP_END_TEXT: begin
				if (holding) begin
					encode_digraph(held_letter, LETTER_X, 1'b1);
					holding = 1'b0;
				end else begin
					expected_cipher.push_back('{cipher_letter: '0, has_letter: 1'b0,
						end_of_message: 1'b1});
				end
			end
			default: ;
		endcase
	endfunction

	// Drive one input beat, with a random gap first, and wait until it is taken.
	task automatic send_item(input logic [2:0] op, input letter_t l);
		@(negedge clk);
		if ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			item       <= item_t'(8'($urandom_range(255)));
			do
				@(negedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
		item       <= '{operation: op, letter: l};
		item_valid <= 1'b1;
		do
			@(posedge clk);
		while (item_stall !== 1'b0);
		items_sent++;
		predict_cipher(op, l);
	endtask

	// Drop valid and wait until every expected result beat has come.
	task automatic drain_results();
		@(negedge clk);
		item_valid <= 1'b0;
		while (expected_cipher.size() != 0)
			@(posedge clk);
	endtask

	// Key square edge cases: ignored letters, repeats, unused codes.
	task automatic test_key_building();
		send_item(OP_END_TEXT, '0);
		send_item(OP_TEXT_LETTER, LETTER_Q);
		send_item(OP_TEXT_LETTER, TOP_CODE);
		send_item(OP_NEW_KEY, '0);
		send_item(OP_KEY_LETTER, code_of("Z"));
		send_item(OP_KEY_LETTER, code_of("A"));
		send_item(OP_KEY_LETTER, LETTER_Q);
		send_item(OP_KEY_LETTER, TOP_CODE);
		send_item(OP_KEY_LETTER, BEYOND_Z);
		send_item(OP_KEY_LETTER, code_of("Z"));
		send_item(OP_FINISH_KEY, '0);
		send_item(OP_UNUSED, TOP_CODE);
	endtask

	// Pair rules on the square Z A B C D / E F G H I / J K L M N / O P R S T / U V W X Y.
	task automatic test_text_cases();
		// Same row with wrap, same column with wrap, then a rectangle.
		send_item(OP_TEXT_LETTER, code_of("Z"));
		send_item(OP_TEXT_LETTER, code_of("D"));
		send_item(OP_TEXT_LETTER, code_of("Z"));
		send_item(OP_TEXT_LETTER, code_of("U"));
		send_item(OP_TEXT_LETTER, code_of("B"));
		send_item(OP_TEXT_LETTER, code_of("H"));
		// Doubled letter, then an ignored code keeps the held letter.
		send_item(OP_TEXT_LETTER, code_of("L"));
		send_item(OP_TEXT_LETTER, code_of("L"));
		send_item(OP_TEXT_LETTER, TOP_CODE);
		send_item(OP_TEXT_LETTER, code_of("M"));
		// X with X is a same-row pair, and the odd X closes the message.
		send_item(OP_TEXT_LETTER, LETTER_X);
		send_item(OP_TEXT_LETTER, LETTER_X);
		send_item(OP_END_TEXT, '0);
		// A new key drops the held letter.
		send_item(OP_TEXT_LETTER, code_of("Y"));
		send_item(OP_NEW_KEY, '0);
		send_item(OP_FINISH_KEY, '0);
		send_item(OP_END_TEXT, '0);
	endtask

	// The sender waits for the block to run dry before the message ends.
	task automatic test_drain_pause();
		recv_stall_pct = 57;
		send_item(OP_TEXT_LETTER, code_of("A"));
		send_item(OP_TEXT_LETTER, code_of("W"));
		send_item(OP_TEXT_LETTER, code_of("K"));
		drain_results();
		send_item(OP_END_TEXT, '0);
		recv_stall_pct = 0;
	endtask

	// New key with random letters; now and then all 25 letters and more.
	task automatic send_random_key();
		letter_t pool [SQUARE_CELLS];
		letter_t swap;
		int i, j, n;
		send_item(OP_NEW_KEY, letter_t'($urandom_range(31)));
		if ($urandom_range(9) == 0) begin
			n = 0;
			for (i = 0; i < LETTER_COUNT; i++)
				if (letter_t'(i) != LETTER_Q) begin
					pool[n] = letter_t'(i);
					n++;
				end
			for (i = SQUARE_CELLS - 1; i > 0; i--) begin
				j       = $urandom_range(i);
				swap    = pool[i];
				pool[i] = pool[j];
				pool[j] = swap;
			end
			for (i = 0; i < SQUARE_CELLS; i++)
				send_item(OP_KEY_LETTER, pool[i]);
			n = 2;
		end else begin
			n = $urandom_range(12);
		end
		for (i = 0; i < n; i++)
			send_item(OP_KEY_LETTER, ($urandom_range(7) == 0) ?
				letter_t'($urandom_range(31)) : any_square_letter());
		// Occasionally the key is left unfinished and stale cells are used.
		if ($urandom_range(15) != 0)
			send_item(OP_FINISH_KEY, letter_t'($urandom_range(31)));
	endtask

	// Messages of random text, doubled letters and some noise beats.
	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
			input int item_count);
		int stop_at, i, n, pick;
		letter_t last_text;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		stop_at        = items_sent + item_count;
		last_text      = any_square_letter();
		while (items_sent < stop_at) begin
			if ($urandom_range(3) == 0)
				send_random_key();
			n = $urandom_range(14);
			for (i = 0; i < n; i++) begin
				pick = $urandom_range(19);
				if (pick == 0) begin
					send_item(3'($urandom_range(7)), letter_t'($urandom_range(31)));
				end else if (pick == 1) begin
					send_item(OP_TEXT_LETTER, letter_t'($urandom_range(31)));
				end else begin
					if (pick > 4)
						last_text = any_square_letter();
					send_item(OP_TEXT_LETTER, last_text);
				end
			end
			if ($urandom_range(9) != 0)
				send_item(OP_END_TEXT, letter_t'($urandom_range(31)));
		end
	endtask

	// Receiver stall, redrawn every cycle.
	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	// Compare each accepted result beat with the oldest expected one.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_cipher.size() == 0) begin
				$display("%0t: result beat with nothing expected: letter %0d has %0b end %0b",
					$time, result.cipher_letter, result.has_letter, result.end_of_message);
				mismatches++;
			end else begin
				want = expected_cipher.pop_front();
				if (result.cipher_letter !== want.cipher_letter) begin
					$display("%0t: cipher_letter expected %0d, got %0d",
						$time, want.cipher_letter, result.cipher_letter);
					mismatches++;
				end
				if (result.has_letter !== want.has_letter) begin
					$display("%0t: has_letter expected %0b, got %0b",
						$time, want.has_letter, result.has_letter);
					mismatches++;
				end
				if (result.end_of_message !== want.end_of_message) begin
					$display("%0t: end_of_message expected %0b, got %0b",
						$time, want.end_of_message, result.end_of_message);
					mismatches++;
				end
			end
		end
	end

	// Watchdog on cycles in which neither side moves a beat.
	always @(posedge clk) begin
		if ((item_valid && item_stall === 1'b0) || (result_valid === 1'b1 && !result_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		clear_cipher_state();
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_key_building();
		test_text_cases();
		test_drain_pause();
		test_random_traffic(0, 0, 145);
		test_random_traffic(57, 0, 145);
		test_random_traffic(0, 57, 145);
		test_random_traffic(35, 35, 145);

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
